// ===== hw/rtl/extended_gcd_assert.svh =====
// Assertion macros used by the checker file of the extended GCD block.
`ifndef EXTENDED_GCD_ASSERT_SVH
`define EXTENDED_GCD_ASSERT_SVH

// Property checked on every rising edge while reset is released.
`define EGCD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("extended_gcd check failed");

// Property checked on every rising edge, reset included.
`define EGCD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("extended_gcd check failed");

`endif

// ===== hw/rtl/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// Widths and the command and status types shared by the extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;

    // Operand width and derived widths.
    localparam int WIDTH = 32;
    localparam int COEF_W = WIDTH + 1;
    localparam int CNT_W = $clog2(WIDTH);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new operand pair
        logic div_init;  // start a division of x by y
        logic div_step;  // one quotient bit
        logic update;    // apply the remainder and coefficient recurrences
        logic out_load;  // copy the finished result to the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic y_zero;    // the divisor is zero, so the loop is finished
    } t_dp_sts;

endpackage

// ===== hw/rtl/egcd_if.sv =====
// ----------------------------------------------------------------------------
// egcd_if
// Valid/ready stream interfaces for operand pairs and for results.
// ----------------------------------------------------------------------------
interface egcd_in_if;
    logic                          valid;
    logic                          ready;
    logic [egcd_pkg::WIDTH-1:0]    operand_a;
    logic [egcd_pkg::WIDTH-1:0]    operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [egcd_pkg::WIDTH-1:0]    gcd_value;
    logic signed [egcd_pkg::COEF_W-1:0]   coef_a;
    logic signed [egcd_pkg::COEF_W-1:0]   coef_b;

    modport source (output valid, output gcd_value, output coef_a, output coef_b,
                    input ready);
    modport sink (input valid, input gcd_value, input coef_a, input coef_b,
                  output ready);
endinterface

// ===== hw/rtl/egcd_datapath.sv =====
// ----------------------------------------------------------------------------
// egcd_datapath
// Remainder and coefficient registers, a bit-serial restoring divider with
// serial quotient-times-coefficient accumulation, and the result register.
// ----------------------------------------------------------------------------
module egcd_datapath (
    input  logic                                  i_clk,
    input  egcd_pkg::t_dp_cmd                     i_cmd,
    input  logic        [egcd_pkg::WIDTH-1:0]     i_operand_a,
    input  logic        [egcd_pkg::WIDTH-1:0]     i_operand_b,
    output egcd_pkg::t_dp_sts                     o_sts,
    output logic        [egcd_pkg::WIDTH-1:0]     o_gcd_value,
    output logic signed [egcd_pkg::COEF_W-1:0]    o_coef_a,
    output logic signed [egcd_pkg::COEF_W-1:0]    o_coef_b
);

    localparam int W = egcd_pkg::WIDTH;
    localparam int CW = egcd_pkg::COEF_W;

    // Remainder pair, larger one in x.
    logic [W-1:0]  r_x, r_y;
    // Coefficients of the current and next remainder, per operand slot.
    logic [CW-1:0] r_cf, r_cs, r_nf, r_ns;
    // Divider: partial remainder and dividend/quotient shift register.
    logic [W-1:0]  r_rem, r_dq;
    // Serial products q*nf and q*ns.
    logic [CW-1:0] r_pf, r_ps;
    logic          r_exch;
    // Output register.
    logic [W-1:0]  r_gcd;
    logic [CW-1:0] r_coef_a, r_coef_b;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          qbit;

    // One restoring division step.
    always_comb begin
        trial = {r_rem, r_dq[W-1]};
        diff  = trial - {1'b0, r_y};
        qbit  = (trial >= {1'b0, r_y});
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_operand_b > i_operand_a) begin
                r_x    <= i_operand_b;
                r_y    <= i_operand_a;
                r_exch <= 1'b1;
            end else begin
                r_x    <= i_operand_a;
                r_y    <= i_operand_b;
                r_exch <= 1'b0;
            end
            r_cf <= CW'(1);
            r_cs <= '0;
            r_nf <= '0;
            r_ns <= CW'(1);
        end else if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dq  <= r_x;
            r_pf  <= '0;
            r_ps  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? diff[W-1:0] : trial[W-1:0];
            r_dq  <= {r_dq[W-2:0], qbit};
            r_pf  <= {r_pf[CW-2:0], 1'b0} + (qbit ? r_nf : '0);
            r_ps  <= {r_ps[CW-2:0], 1'b0} + (qbit ? r_ns : '0);
        end else if (i_cmd.update) begin
            r_x  <= r_y;
            r_y  <= r_rem;
            r_cf <= r_nf;
            r_cs <= r_ns;
            r_nf <= r_cf - r_pf;
            r_ns <= r_cs - r_ps;
        end
    end

    // Result register, coefficient slots restored to the operand order.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_gcd    <= r_x;
            r_coef_a <= r_exch ? r_cs : r_cf;
            r_coef_b <= r_exch ? r_cf : r_cs;
        end
    end

    assign o_sts.y_zero = (r_y == '0);
    assign o_gcd_value  = r_gcd;
    assign o_coef_a     = r_coef_a;
    assign o_coef_b     = r_coef_b;

endmodule

// ===== hw/rtl/egcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the Euclidean loop: check, divide bit by bit, update, and
// hand the result to the output register.
// ----------------------------------------------------------------------------
module egcd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  egcd_pkg::t_dp_sts   i_sts,
    output egcd_pkg::t_dp_cmd   o_cmd
);

    localparam int W = egcd_pkg::WIDTH;
    localparam int CNT_W = egcd_pkg::CNT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_UPD   = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.y_zero) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_out_valid    = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/extended_gcd.sv =====
// The result follows n division steps, n being at most 45 for 32-bit operands;
// each step is a check, a bit-serial division of WIDTH quotient bits and an
// update. A new operand pair is taken only after the last result has been
// loaded into the output register.
// A finished result waits in the output register while the next pair starts.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// extended_gcd
// Extended Euclidean algorithm: gcd and Bezout coefficients of two operands.
// ----------------------------------------------------------------------------
module extended_gcd (
    input  logic       i_clk,
    input  logic       i_rst_n,
    egcd_in_if.sink    i_in,
    egcd_out_if.source o_out
);

    egcd_pkg::t_dp_cmd cmd;
    egcd_pkg::t_dp_sts sts;

    // Loop sequencer.
    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and result storage.
    egcd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_operand_a (i_in.operand_a),
        .i_operand_b (i_in.operand_b),
        .o_sts       (sts),
        .o_gcd_value (o_out.gcd_value),
        .o_coef_a    (o_out.coef_a),
        .o_coef_b    (o_out.coef_b)
    );

endmodule

// ===== hw/rtl/egcd_checker.sv =====
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks on the extended GCD block, bound to its top level.
// ----------------------------------------------------------------------------
`include "extended_gcd_assert.svh"

module egcd_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  i_in_ready,
    input logic        [egcd_pkg::WIDTH-1:0]     i_operand_a,
    input logic        [egcd_pkg::WIDTH-1:0]     i_operand_b,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic        [egcd_pkg::WIDTH-1:0]     i_gcd_value,
    input logic signed [egcd_pkg::COEF_W-1:0]    i_coef_a,
    input logic signed [egcd_pkg::COEF_W-1:0]    i_coef_b
);

    localparam int W = egcd_pkg::WIDTH;
    localparam int CW = egcd_pkg::COEF_W;

    logic              in_xfer;
    logic              out_stall;
    logic [W+2*CW-1:0] out_word;
    logic [W-1:0]      r_last_a;
    logic              b_zero_xfer;
    logic              zero_match;

    assign in_xfer   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_word  = {i_gcd_value, i_coef_a, i_coef_b};

    // First operand of the latest input transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_last_a <= i_operand_a;
        end
    end

    assign b_zero_xfer = in_xfer && (i_operand_b == '0) && !i_out_valid;
    assign zero_match  = i_out_valid && (i_gcd_value == r_last_a) &&
                         (i_coef_a == CW'(1)) && (i_coef_b == '0);

    // A stalled result keeps its valid and its value.
    `EGCD_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid)
    `EGCD_ASSERT(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(out_word))

    // The block is busy in the cycle after it takes a pair.
    `EGCD_ASSERT(a_busy, i_clk, i_rst_n, in_xfer |=> !i_in_ready)

    // A zero second operand, taken while no result is held, finishes at once with coefficients one and zero.
    `EGCD_ASSERT(a_b_zero, i_clk, i_rst_n, b_zero_xfer |-> ##2 zero_match)

    // Reset empties the output register.
    `EGCD_ASSERT_ALWAYS(a_reset, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind extended_gcd egcd_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_operand_a (i_in.operand_a),
    .i_operand_b (i_in.operand_b),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_gcd_value (o_out.gcd_value),
    .i_coef_a    (o_out.coef_a),
    .i_coef_b    (o_out.coef_b)
);
